FILE: src/coc_pkg.sv
// shared constants, types and helpers for the container order classifier
package coc_pkg;

  localparam int unsigned DEPTH_DEF      = 1024;
  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned IN_WIDTH       = 32;
  localparam int unsigned VERDICT_W      = 3;

  localparam logic CMD_PUSH   = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  localparam logic [VERDICT_W-1:0] VERDICT_IMPOSSIBLE = 3'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_SURE   = 3'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_STACK      = 3'd2;
  localparam logic [VERDICT_W-1:0] VERDICT_QUEUE      = 3'd3;
  localparam logic [VERDICT_W-1:0] VERDICT_HEAP       = 3'd4;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LATCH     = 4'd1,  // capture request, clear on first
    OP_PUSH_WR   = 4'd2,  // write lifo and fifo, set up sift-up
    OP_UP_RD     = 4'd3,  // read heap parent
    OP_UP_CMP    = 4'd4,  // compare parent, move down or place
    OP_POP_RD    = 4'd5,  // read lifo top, fifo head, heap root
    OP_POP_LAST  = 4'd6,  // check tops, read heap last
    OP_DN_RD0    = 4'd7,  // read left child, or place at a leaf
    OP_DN_RD1    = 4'd8,  // read right child
    OP_DN_CMP    = 4'd9,  // pick child, move up or place
    OP_EMPTY     = 4'd10, // removal on empty store
    OP_FULL      = 4'd11  // dropped push
  } op_t;

  typedef struct packed {
    logic is_remove;
    logic empty;
    logic full;
    logic up_done;   // sift-up reached root or parent not smaller
    logic dn_done;   // no left child
    logic has_right; // right child exists
  } dp_status_t;

  function automatic logic [VERDICT_W-1:0] verdict_of(input logic [2:0] f);
    logic [VERDICT_W-1:0] v;
    v = VERDICT_NOT_SURE;
    case (f)
      3'b000:  v = VERDICT_IMPOSSIBLE;
      3'b001:  v = VERDICT_STACK;
      3'b010:  v = VERDICT_QUEUE;
      3'b100:  v = VERDICT_HEAP;
      default: v = VERDICT_NOT_SURE;
    endcase
    return v;
  endfunction

endpackage

FILE: src/coc_datapath.sv
// stores, counters, flags and compare logic of the classifier
module coc_datapath #(
  parameter int unsigned DEPTH      = coc_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = coc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  coc_pkg::op_t                        op,
  input  logic                                in_cmd,
  input  logic signed [coc_pkg::IN_WIDTH-1:0] in_value,
  input  logic                                in_first,
  output coc_pkg::dp_status_t                 status,
  output logic [2:0]                          flags,
  output logic                                full_res
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  logic [DATA_WIDTH-1:0] lifo_mem [DEPTH];
  logic [DATA_WIDTH-1:0] fifo_mem [DEPTH];
  logic [DATA_WIDTH-1:0] heap_mem [DEPTH];

  logic [CW-1:0]         count_r, count_nxt;
  logic [AW-1:0]         head_r, head_nxt;
  logic [2:0]            flags_r, flags_nxt;
  logic                  full_r, full_nxt;
  logic                  cmd_r;
  logic [DATA_WIDTH-1:0] val_r;
  logic [DATA_WIDTH-1:0] last_r;   // value being sifted
  logic [CW-1:0]         idx_r;    // current hole
  logic [CW-1:0]         n_r;      // heap size after removal
  logic [DATA_WIDTH-1:0] s_rd_r, q_rd_r, h_rd_r, c0_r;

  logic [DATA_WIDTH-1:0] vnorm;
  logic [CW-1:0]         tail_sum, parent, lchild, rchild;
  logic                  r_gt_l;
  logic [DATA_WIDTH-1:0] best;
  logic [CW-1:0]         best_idx;

  // sign extend or truncate the request value
  always_comb begin
    vnorm = DATA_WIDTH'(in_value);
    if (DATA_WIDTH > coc_pkg::IN_WIDTH) begin
      vnorm = DATA_WIDTH'({{(64 - coc_pkg::IN_WIDTH){in_value[coc_pkg::IN_WIDTH-1]}},
                          in_value});
    end
  end

  assign tail_sum = CW'({1'b0, head_r}) + count_r;
  assign parent   = (idx_r - CW'(1)) >> 1;
  assign lchild   = CW'({idx_r, 1'b1});
  assign rchild   = lchild + CW'(1);
  assign r_gt_l   = $signed(h_rd_r) > $signed(c0_r);
  assign best     = (status.has_right && r_gt_l) ? h_rd_r : c0_r;
  assign best_idx = (status.has_right && r_gt_l) ? rchild : lchild;

  assign status.is_remove = cmd_r;
  assign status.empty     = (count_r == '0);
  assign status.full      = (count_r == DEPTH_C);
  assign status.up_done   = (idx_r == '0) || !($signed(last_r) > $signed(h_rd_r));
  assign status.dn_done   = ({1'b0, idx_r} << 1) + (CW + 1)'(1) >= {1'b0, n_r};
  assign status.has_right = ({1'b0, rchild}) < {1'b0, n_r};

  always_comb begin
    count_nxt = count_r;
    head_nxt  = head_r;
    flags_nxt = flags_r;
    full_nxt  = full_r;
    case (op)
      coc_pkg::OP_LATCH: begin
        if (in_first) begin
          count_nxt = '0;
          head_nxt  = '0;
          flags_nxt = 3'b111;
        end
        full_nxt = 1'b0;
      end
      coc_pkg::OP_FULL:  full_nxt = 1'b1;
      coc_pkg::OP_EMPTY: flags_nxt = 3'b000;
      coc_pkg::OP_PUSH_WR: count_nxt = count_r + CW'(1);
      coc_pkg::OP_POP_LAST: begin
        if (s_rd_r != val_r) flags_nxt[0] = 1'b0;
        if (q_rd_r != val_r) flags_nxt[1] = 1'b0;
        if (h_rd_r != val_r) flags_nxt[2] = 1'b0;
        count_nxt = count_r - CW'(1);
        head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      head_r  <= '0;
      flags_r <= 3'b111;
      full_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      head_r  <= head_nxt;
      flags_r <= flags_nxt;
      full_r  <= full_nxt;
    end
  end

  // memory ports and sift registers
  always_ff @(posedge clk) begin
    case (op)
      coc_pkg::OP_LATCH: begin
        cmd_r <= in_cmd;
        val_r <= vnorm;
      end
      coc_pkg::OP_PUSH_WR: begin
        lifo_mem[count_r[AW-1:0]] <= val_r;
        fifo_mem[(tail_sum >= DEPTH_C) ? AW'(tail_sum - DEPTH_C) : AW'(tail_sum)] <= val_r;
        last_r <= val_r;
        idx_r  <= count_r;
      end
      coc_pkg::OP_UP_RD: h_rd_r <= heap_mem[parent[AW-1:0]];
      coc_pkg::OP_UP_CMP: begin
        if (status.up_done) begin
          heap_mem[idx_r[AW-1:0]] <= last_r;
        end else begin
          heap_mem[idx_r[AW-1:0]] <= h_rd_r;
          idx_r <= parent;
        end
      end
      coc_pkg::OP_POP_RD: begin
        s_rd_r <= lifo_mem[AW'(count_r - CW'(1))];
        q_rd_r <= fifo_mem[head_r];
        h_rd_r <= heap_mem[0];
      end
      coc_pkg::OP_POP_LAST: begin
        last_r  <= heap_mem[AW'(count_r - CW'(1))];
        n_r     <= count_r - CW'(1);
        idx_r   <= '0;
      end
      coc_pkg::OP_DN_RD0: begin
        if (status.dn_done) begin
          if (n_r != '0) heap_mem[idx_r[AW-1:0]] <= last_r;
        end else begin
          c0_r <= heap_mem[lchild[AW-1:0]];
        end
      end
      coc_pkg::OP_DN_RD1: begin
        if (status.has_right) h_rd_r <= heap_mem[rchild[AW-1:0]];
      end
      coc_pkg::OP_DN_CMP: begin
        if ($signed(best) > $signed(last_r)) begin
          heap_mem[idx_r[AW-1:0]] <= best;
          idx_r <= best_idx;
        end else begin
          heap_mem[idx_r[AW-1:0]] <= last_r;
          n_r <= '0;  // mark placed
          idx_r <= '0;
        end
      end
      default: ;
    endcase
  end

  assign flags    = flags_r;
  assign full_res = full_r;
endmodule

FILE: src/coc_controller.sv
// sequencing state machine of the classifier
module coc_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  coc_pkg::dp_status_t status,
  output coc_pkg::op_t        op
);
  typedef enum logic [9:0] {
    ST_IDLE   = 10'b0000000001,
    ST_DEC    = 10'b0000000010,
    ST_PUSH   = 10'b0000000100,
    ST_UP_RD  = 10'b0000001000,
    ST_UP_CMP = 10'b0000010000,
    ST_POP_L  = 10'b0000100000,
    ST_DN_RD0 = 10'b0001000000,
    ST_DN_RD1 = 10'b0010000000,
    ST_DN_CMP = 10'b0100000000,
    ST_OUT    = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);

  always_comb begin
    state_nxt = state_r;
    op        = coc_pkg::OP_NONE;
    unique case (state_r)
      ST_IDLE: if (in_valid) begin
        op = coc_pkg::OP_LATCH;
        state_nxt = ST_DEC;
      end
      ST_DEC: begin
        if (!status.is_remove) begin
          if (status.full) begin
            op = coc_pkg::OP_FULL;
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_PUSH;
          end
        end else if (status.empty) begin
          op = coc_pkg::OP_EMPTY;
          state_nxt = ST_OUT;
        end else begin
          op = coc_pkg::OP_POP_RD;
          state_nxt = ST_POP_L;
        end
      end
      ST_PUSH: begin
        op = coc_pkg::OP_PUSH_WR;
        state_nxt = ST_UP_RD;
      end
      ST_UP_RD: begin
        op = coc_pkg::OP_UP_RD;
        state_nxt = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        op = coc_pkg::OP_UP_CMP;
        state_nxt = status.up_done ? ST_OUT : ST_UP_RD;
      end
      ST_POP_L: begin
        op = coc_pkg::OP_POP_LAST;
        state_nxt = ST_DN_RD0;
      end
      ST_DN_RD0: begin
        op = coc_pkg::OP_DN_RD0;
        state_nxt = status.dn_done ? ST_OUT : ST_DN_RD1;
      end
      ST_DN_RD1: begin
        op = coc_pkg::OP_DN_RD1;
        state_nxt = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        op = coc_pkg::OP_DN_CMP;
        state_nxt = ST_DN_RD0;
      end
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

FILE: src/container_order_classifier_unit.sv
// top level of the container order classifier
// Each request pushes a value into, or removes and checks a value against, a
// stack, a queue and a max heap kept side by side; the result reports which
// orders still fit plus a verdict. One request is in flight at a time. A push
// sifts the new value up the heap and a removal sifts the last heap value
// down; each level walked takes reads and a compare on the single-port heap
// memory. Dropped pushes and removals on an empty store go straight to the
// result. No clearing pass is needed after reset: the stores are read only
// below the fill count.
module container_order_classifier_unit #(
  parameter int unsigned DEPTH      = coc_pkg::DEPTH_DEF,
  parameter int unsigned DATA_WIDTH = coc_pkg::DATA_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // request channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_cmd,
  input  logic signed [coc_pkg::IN_WIDTH-1:0]  in_value,
  input  logic                                 in_first,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [coc_pkg::VERDICT_W-1:0]        out_verdict,
  output logic                                 out_stack_ok,
  output logic                                 out_queue_ok,
  output logic                                 out_heap_ok,
  output logic                                 out_full_res
);
  coc_pkg::op_t        op;
  coc_pkg::dp_status_t status;
  logic [2:0]          flags;

  coc_controller u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .status, .op
  );

  coc_datapath #(.DEPTH(DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
    .clk, .rst_n, .op, .in_cmd, .in_value, .in_first,
    .status, .flags, .full_res(out_full_res)
  );

  // result fields come straight from the held flags
  assign out_stack_ok = flags[0];
  assign out_queue_ok = flags[1];
  assign out_heap_ok  = flags[2];
  assign out_verdict  = coc_pkg::verdict_of(flags);
endmodule

FILE: verif/testbench.sv
// testbench for the container order classifier: directed and random requests
`timescale 1ns / 100ps

module testbench;
  import coc_pkg::*;

  localparam int unsigned DEPTH = DEPTH_DEF;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic in_cmd;
  logic signed [IN_WIDTH-1:0] in_value;
  logic in_first;
  logic out_valid;
  logic out_ready;
  logic [VERDICT_W-1:0] out_verdict;
  logic out_stack_ok;
  logic out_queue_ok;
  logic out_heap_ok;
  logic out_full_res;

  typedef struct packed {
    logic [VERDICT_W-1:0] verdict;
    logic stack_ok;
    logic queue_ok;
    logic heap_ok;
    logic full_res;
  } verdict_rec_t;

  // shadow containers, each modeled in its plainest form
  logic signed [31:0] shadow_stack[$];
  logic signed [31:0] shadow_queue[$];
  logic signed [31:0] shadow_heap[$];
  logic [2:0]         shadow_flags;
  verdict_rec_t       pending_verdicts[$];

  int mismatch_count;
  int send_idle_pct;
  int recv_stall_pct;
  bit recv_hold;

  container_order_classifier_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .in_first     (in_first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_verdict  (out_verdict),
    .out_stack_ok (out_stack_ok),
    .out_queue_ok (out_queue_ok),
    .out_heap_ok  (out_heap_ok),
    .out_full_res (out_full_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // shadow of one request; returns the expected result
  function automatic verdict_rec_t classify_request(logic cmd, logic signed [31:0] val,
                                                    logic first);
    verdict_rec_t r;
    int best;
    logic signed [31:0] top;
    r = '0;
    if (first) begin
      shadow_stack.delete();
      shadow_queue.delete();
      shadow_heap.delete();
      shadow_flags = 3'b111;
    end
    if (cmd == CMD_PUSH) begin
      if (shadow_stack.size() >= DEPTH) begin
        // full store: push dropped, nothing changes
        r.full_res = 1'b1;
      end else begin
        shadow_stack.push_back(val);
        shadow_queue.push_back(val);
        shadow_heap.push_back(val);
      end
    end else if (shadow_stack.size() == 0) begin
      // removal on empty: every order is ruled out
      shadow_flags = 3'b000;
    end else begin
      if (shadow_stack.pop_back() != val) shadow_flags[0] = 1'b0;
      if (shadow_queue.pop_front() != val) shadow_flags[1] = 1'b0;
      // any equal maximum serves, so only the value matters
      best = 0;
      for (int i = 1; i < shadow_heap.size(); i++)
        if (shadow_heap[i] > shadow_heap[best]) best = i;
      top = shadow_heap[best];
      shadow_heap.delete(best);
      if (top != val) shadow_flags[2] = 1'b0;
    end
    r.stack_ok = shadow_flags[0];
    r.queue_ok = shadow_flags[1];
    r.heap_ok  = shadow_flags[2];
    case (shadow_flags)
      3'b000:  r.verdict = VERDICT_IMPOSSIBLE;
      3'b001:  r.verdict = VERDICT_STACK;
      3'b010:  r.verdict = VERDICT_QUEUE;
      3'b100:  r.verdict = VERDICT_HEAP;
      default: r.verdict = VERDICT_NOT_SURE;
    endcase
    return r;
  endfunction

  // offer one request, hold it until accepted, then log the expectation
  // valid stays high into the next request unless the sender idles
  task automatic send_request(logic cmd, logic signed [31:0] val, logic first);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_value <= val;
    in_first <= first;
    do @(posedge clk); while (!in_ready);
    pending_verdicts.push_back(classify_request(cmd, val, first));
  endtask

  // receiver side: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // result checker
  always @(posedge clk) begin
    verdict_rec_t want;
    verdict_rec_t got;
    if (rst_n && out_valid && out_ready) begin
      got = {out_verdict, out_stack_ok, out_queue_ok, out_heap_ok, out_full_res};
      if (pending_verdicts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_verdicts.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: verdict %0d/%0d stack %b/%b queue %b/%b heap %b/%b full %b/%b",
                     want.verdict, got.verdict, want.stack_ok, got.stack_ok,
                     want.queue_ok, got.queue_ok, want.heap_ok, got.heap_ok,
                     want.full_res, got.full_res);
        end
      end
    end
  end

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(5))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return $urandom_range(7);
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  // extremes, both commands, empty removal, ties and first-of-case
  task automatic test_directed();
    send_request(CMD_REMOVE, 0, 1'b0);
    send_request(CMD_PUSH, 32'sh7fff_ffff, 1'b1);
    send_request(CMD_PUSH, 32'sh8000_0000, 1'b0);
    send_request(CMD_PUSH, 0, 1'b0);
    send_request(CMD_PUSH, -1, 1'b0);
    send_request(CMD_REMOVE, -1, 1'b0);
    send_request(CMD_REMOVE, 32'sh7fff_ffff, 1'b0);
    send_request(CMD_REMOVE, 32'sh8000_0000, 1'b0);
    send_request(CMD_REMOVE, 0, 1'b0);
    send_request(CMD_PUSH, 5, 1'b1);
    send_request(CMD_PUSH, 5, 1'b0);
    send_request(CMD_PUSH, 3, 1'b0);
    send_request(CMD_REMOVE, 5, 1'b0);
    send_request(CMD_REMOVE, 5, 1'b0);
    send_request(CMD_REMOVE, 3, 1'b0);
    send_request(CMD_REMOVE, 3, 1'b0);
    send_request(CMD_REMOVE, 9, 1'b1);
    send_request(CMD_PUSH, 1, 1'b1);
    send_request(CMD_PUSH, 2, 1'b0);
    send_request(CMD_REMOVE, 1, 1'b0);
    send_request(CMD_REMOVE, 2, 1'b0);
  endtask

  // fill to capacity, overflow, then remove 40 with random values
  task automatic test_full_store();
    send_request(CMD_PUSH, $urandom, 1'b1);
    for (int i = 1; i < DEPTH; i++) send_request(CMD_PUSH, i, 1'b0);
    send_request(CMD_PUSH, 32'sh7fff_ffff, 1'b0);
    send_request(CMD_PUSH, 1, 1'b0);
    for (int i = 0; i < 40; i++) send_request(CMD_REMOVE, rand_value(), 1'b0);
  endtask

  // well-formed cases that follow one order, plus some noise
  task automatic test_random_cases(int n_items);
    int sent;
    int kind;
    int len;
    logic signed [31:0] val;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(9);
      len  = $urandom_range(1, 8);
      if (kind == 9) begin
        for (int i = 0; i < len; i++)
          send_request(logic'($urandom_range(1)), rand_value(), ($urandom_range(15) == 0));
        sent += len;
      end else begin
        send_request(CMD_PUSH, rand_value(), 1'b1);
        for (int i = 1; i < len; i++) send_request(CMD_PUSH, rand_value(), 1'b0);
        sent += len;
        for (int i = 0; i < len; i++) begin
          // pick the answer a stack, a queue or a heap would give
          if (kind < 3) val = shadow_stack[$];
          else if (kind < 6) val = shadow_queue[0];
          else begin
            val = shadow_heap[0];
            foreach (shadow_heap[j]) if (shadow_heap[j] > val) val = shadow_heap[j];
          end
          if ($urandom_range(19) == 0) val = rand_value();
          send_request(CMD_REMOVE, val, 1'b0);
        end
        sent += len;
      end
    end
  endtask

  // receiver holds off while requests keep coming
  task automatic test_backpressure();
    fork
      begin
        recv_hold = 1'b1;
        repeat (600) @(posedge clk);
        recv_hold = 1'b0;
      end
      begin
        test_random_cases(40);
        in_valid <= 1'b0;
      end
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_cmd = CMD_PUSH;
    in_value = '0;
    in_first = 1'b0;
    recv_hold = 1'b0;
    mismatch_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    shadow_flags = 3'b111;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_full_store();
    test_random_cases(30);
    send_idle_pct = 65;
    test_random_cases(30);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    test_random_cases(30);
    send_idle_pct = 18;
    recv_stall_pct = 18;
    test_random_cases(30);
    test_backpressure();

    wait_drained();
    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && pending_verdicts.size() == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end

endmodule
